// File: rtl/core/gpn_pkg.sv
// ----------------------------------------------------------------------------
// gpn_pkg
// Shared types, constants and the button remap table for the poll normalizer.
// ----------------------------------------------------------------------------
package gpn_pkg;

	localparam int GPN_PORTS = 4;
	localparam int GPN_PORT_W = 2;
	localparam int GPN_PORT_SLOTS = 2 ** GPN_PORT_W;

	localparam int GPN_QDEPTH = 2;
	localparam int GPN_QAW = $clog2(GPN_QDEPTH);

	localparam logic [7:0] GPN_CENTER = 8'd128;
	localparam logic [7:0] GPN_AXIS_MAX = 8'd255;
	localparam logic [7:0] GPN_AXIS_MIN = 8'd0;
	localparam logic [7:0] GPN_COUNT_MAX = 8'd255;

	localparam logic [7:0] GPN_RST_DISCONNECT_LIMIT = 8'd30;
	localparam logic [7:0] GPN_RST_PAK_INIT_POLL = 8'd10;
	localparam logic [6:0] GPN_RST_STICK_FULL_SCALE = 7'd84;

	// configuration register indexes
	localparam logic [1:0] GPN_REG_DISCONNECT_LIMIT = 2'd0;
	localparam logic [1:0] GPN_REG_PAK_INIT_POLL = 2'd1;
	localparam logic [1:0] GPN_REG_STICK_FULL_SCALE = 2'd2;

	// raw button bit positions
	localparam int GPN_RAW_CUP = 10;
	localparam int GPN_RAW_CDOWN = 11;
	localparam int GPN_RAW_CLEFT = 12;
	localparam int GPN_RAW_CRIGHT = 13;

	// source raw bit for each mapped bit
	localparam logic [3:0] GPN_BTN_SRC [14] = '{
		4'd0, 4'd11, 4'd1, 4'd12, 4'd8, 4'd9, 4'd2,
		4'd3, 4'd10, 4'd13, 4'd4, 4'd5, 4'd6, 4'd7
	};

	typedef struct packed {
		logic [1:0]        port;
		logic              link_up;
		logic              poll_ok;
		logic [13:0]       raw_buttons;
		logic signed [7:0] raw_stick_x;
		logic signed [7:0] raw_stick_y;
		logic              pak_present;
		logic              pak_init_ok;
	} gpn_in_t;

	typedef struct packed {
		logic [1:0]  out_port;
		logic [13:0] mapped_buttons;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
		logic        cleared;
		logic        pak_ready;
		logic        last;
	} gpn_out_t;

	typedef struct packed {
		logic [7:0] disconnect_limit;
		logic [7:0] pak_init_poll;
		logic [6:0] stick_full_scale;
	} gpn_cfg_t;

	// command handed from the front to the back
	typedef struct packed {
		logic [1:0]  port;
		logic        clr;
		logic        dat;
		logic [13:0] mb;
		logic [7:0]  sx;
		logic [7:0]  ny;
		logic [7:0]  rx;
		logic [7:0]  ry;
		logic        pak;
	} gpn_cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PREP,
		B_DIV,
		B_CLR,
		B_DATA
	} gpn_bstate_t;

	function automatic logic [13:0] gpn_remap(input logic [13:0] r);
		logic [13:0] o;
		o = '0;
		for (int i = 0; i < 14; i++) begin
			o[i] = r[GPN_BTN_SRC[i]];
		end
		return o;
	endfunction

endpackage

// File: rtl/core/gpn_front.sv
// ----------------------------------------------------------------------------
// gpn_front
// Accepts polls, tracks per-port connection state and classifies each poll.
// ----------------------------------------------------------------------------
module gpn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              poll_valid,
	output logic              poll_stall,
	input  gpn_pkg::gpn_in_t  poll,
	input  gpn_pkg::gpn_cfg_t cfg,
	input  logic              cmd_full,
	output logic              cmd_push,
	output gpn_pkg::gpn_cmd_t cmd
);

	logic [7:0]  connect_q [gpn_pkg::GPN_PORT_SLOTS];
	logic [7:0]  drop_q    [gpn_pkg::GPN_PORT_SLOTS];
	logic        pak_q     [gpn_pkg::GPN_PORT_SLOTS];
	logic [13:0] lastb_q   [gpn_pkg::GPN_PORT_SLOTS];
	logic [7:0]  lastx_q   [gpn_pkg::GPN_PORT_SLOTS];
	logic [7:0]  lasty_q   [gpn_pkg::GPN_PORT_SLOTS];
	logic        force_q   [gpn_pkg::GPN_PORT_SLOTS];

	logic        accept;
	logic        port_ok;
	logic [7:0]  cc, dc, dc_inc, cc_n, dc_n, cc_lk;
	logic        pak_n, clr, emit;
	logic [13:0] mb, lastb_n;
	logic [7:0]  lastx_n, lasty_n;
	logic        force_n;

	assign poll_stall = cmd_full;
	assign accept = poll_valid && !poll_stall;
	assign port_ok = {30'd0, poll.port} < 32'(gpn_pkg::GPN_PORTS);

	always_comb begin
		cc = connect_q[poll.port];
		dc = drop_q[poll.port];
		mb = gpn_pkg::gpn_remap(poll.raw_buttons);
		dc_inc = (dc == gpn_pkg::GPN_COUNT_MAX) ? dc : dc + 8'd1;
		clr = 1'b0;
		cc_n = cc;
		dc_n = dc;
		cc_lk = cc;
		pak_n = pak_q[poll.port];
		lastb_n = lastb_q[poll.port];
		lastx_n = lastx_q[poll.port];
		lasty_n = lasty_q[poll.port];
		force_n = force_q[poll.port];
		if (!poll.link_up) begin
			if (cc != 8'd0) begin
				dc_n = dc_inc;
				if (dc_inc >= cfg.disconnect_limit) begin
					clr = 1'b1;
					cc_n = 8'd0;
					dc_n = 8'd0;
					pak_n = 1'b0;
					lastb_n = '0;
					lastx_n = '0;
					lasty_n = '0;
				end
			end
		end else begin
			dc_n = 8'd0;
			cc_lk = (cc == 8'd0) ? 8'd1 : cc;
			cc_n = cc_lk;
			if (cc_lk != gpn_pkg::GPN_COUNT_MAX) begin
				cc_n = cc_lk + 8'd1;
				if (cc_n == cfg.pak_init_poll && !pak_n && poll.pak_present
					&& poll.pak_init_ok) begin
					pak_n = 1'b1;
				end
			end
		end
		// emit a valid report on change against the last emitted report, or when forced
		emit = poll.poll_ok && (force_n || mb != lastb_n
			|| poll.raw_stick_x != lastx_n || poll.raw_stick_y != lasty_n);
		if (emit) begin
			lastb_n = mb;
			lastx_n = poll.raw_stick_x;
			lasty_n = poll.raw_stick_y;
			force_n = 1'b0;
		end

		cmd.port = poll.port;
		cmd.clr = clr;
		cmd.dat = emit;
		cmd.mb = mb;
		cmd.sx = poll.raw_stick_x;
		cmd.ny = 8'(8'd0 - poll.raw_stick_y);
		cmd.rx = poll.raw_buttons[gpn_pkg::GPN_RAW_CRIGHT] ? gpn_pkg::GPN_AXIS_MAX :
			(poll.raw_buttons[gpn_pkg::GPN_RAW_CLEFT] ? gpn_pkg::GPN_AXIS_MIN :
			gpn_pkg::GPN_CENTER);
		cmd.ry = poll.raw_buttons[gpn_pkg::GPN_RAW_CDOWN] ? gpn_pkg::GPN_AXIS_MAX :
			(poll.raw_buttons[gpn_pkg::GPN_RAW_CUP] ? gpn_pkg::GPN_AXIS_MIN :
			gpn_pkg::GPN_CENTER);
		cmd.pak = pak_n;
	end

	assign cmd_push = accept && port_ok && (clr || emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gpn_pkg::GPN_PORT_SLOTS; i++) begin
				connect_q[i] <= '0;
				drop_q[i] <= '0;
				pak_q[i] <= 1'b0;
				lastb_q[i] <= '0;
				lastx_q[i] <= '0;
				lasty_q[i] <= '0;
				force_q[i] <= 1'b1;
			end
		end else if (accept && port_ok) begin
			connect_q[poll.port] <= cc_n;
			drop_q[poll.port] <= dc_n;
			pak_q[poll.port] <= pak_n;
			lastb_q[poll.port] <= lastb_n;
			lastx_q[poll.port] <= lastx_n;
			lasty_q[poll.port] <= lasty_n;
			force_q[poll.port] <= force_n;
		end
	end

endmodule

// File: rtl/core/gpn_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gpn_cmd_fifo
// Short queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module gpn_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gpn_pkg::gpn_cmd_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output gpn_pkg::gpn_cmd_t rdata
);

	gpn_pkg::gpn_cmd_t                 mem_q [gpn_pkg::GPN_QDEPTH];
	logic [gpn_pkg::GPN_QAW-1:0]       wr_q, rd_q;
	logic [gpn_pkg::GPN_QAW:0]         cnt_q;
	logic                              do_push, do_pop;

	assign full = cnt_q == (gpn_pkg::GPN_QAW+1)'(gpn_pkg::GPN_QDEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == gpn_pkg::GPN_QAW'(gpn_pkg::GPN_QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == gpn_pkg::GPN_QAW'(gpn_pkg::GPN_QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/gpn_back.sv
// ----------------------------------------------------------------------------
// gpn_back
// Scales the sticks with a shared radix-16 divider pair and emits events.
// ----------------------------------------------------------------------------
module gpn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  gpn_pkg::gpn_cmd_t cmd,
	output logic              cmd_pop,
	input  logic [6:0]        full_scale,
	output logic              evt_valid,
	input  logic              evt_stall,
	output gpn_pkg::gpn_out_t evt
);

	gpn_pkg::gpn_bstate_t state_q, state_n;
	logic                 cnt_q;
	gpn_pkg::gpn_cmd_t    cmd_q;
	logic [7:0]           rem_x_q, rem_y_q, dq_x_q, dq_y_q;
	logic                 big_x_q, big_y_q;
	logic                 evt_valid_q;
	gpn_pkg::gpn_out_t    evt_q, evt_n;
	logic                 slot_free, evt_load;
	logic [7:0]           fs;
	logic [7:0]           mag_x, mag_y;
	logic [14:0]          n_x, n_y, lim;
	logic [15:0]          st_x, st_y;

	function automatic logic [15:0] div4(input logic [15:0] rd, input logic [7:0] d);
		logic [7:0] r, q, r2;
		r = rd[15:8];
		q = rd[7:0];
		for (int i = 0; i < 4; i++) begin
			r2 = {r[6:0], q[7]};
			q = {q[6:0], 1'b0};
			if (r2 >= d) begin
				r2 = r2 - d;
				q[0] = 1'b1;
			end
			r = r2;
		end
		return {r, q};
	endfunction

	function automatic logic [7:0] axis_out(input logic neg, input logic big,
		input logic [7:0] q);
		logic [7:0] m;
		if (neg) begin
			m = (big || q > 8'd128) ? 8'd128 : q;
			return 8'(9'd128 - {1'b0, m});
		end else begin
			m = (big || q > 8'd127) ? 8'd127 : q;
			return 8'(9'd128 + {1'b0, m});
		end
	endfunction

	assign fs = (full_scale == 7'd0) ? 8'd1 : {1'b0, full_scale};
	assign mag_x = cmd_q.sx[7] ? 8'(8'd0 - cmd_q.sx) : cmd_q.sx;
	assign mag_y = cmd_q.ny[7] ? 8'(8'd0 - cmd_q.ny) : cmd_q.ny;
	assign n_x = {mag_x, 7'd0} - {7'd0, mag_x};
	assign n_y = {mag_y, 7'd0} - {7'd0, mag_y};
	assign lim = {fs[6:0], 8'd0};
	assign st_x = div4({rem_x_q, dq_x_q}, fs);
	assign st_y = div4({rem_y_q, dq_y_q}, fs);
	assign slot_free = !evt_valid_q || !evt_stall;

	always_comb begin
		state_n = state_q;
		cmd_pop = 1'b0;
		evt_load = 1'b0;
		evt_n.out_port = cmd_q.port;
		evt_n.mapped_buttons = '0;
		evt_n.left_x = gpn_pkg::GPN_CENTER;
		evt_n.left_y = gpn_pkg::GPN_CENTER;
		evt_n.right_x = gpn_pkg::GPN_CENTER;
		evt_n.right_y = gpn_pkg::GPN_CENTER;
		evt_n.cleared = 1'b1;
		evt_n.pak_ready = 1'b0;
		evt_n.last = !cmd_q.dat;
		case (state_q)
			gpn_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_n = gpn_pkg::B_PREP;
				end
			end
			gpn_pkg::B_PREP: begin
				state_n = gpn_pkg::B_DIV;
			end
			gpn_pkg::B_DIV: begin
				if (cnt_q) begin
					state_n = cmd_q.clr ? gpn_pkg::B_CLR : gpn_pkg::B_DATA;
				end
			end
			gpn_pkg::B_CLR: begin
				if (slot_free) begin
					evt_load = 1'b1;
					state_n = cmd_q.dat ? gpn_pkg::B_DATA : gpn_pkg::B_IDLE;
				end
			end
			gpn_pkg::B_DATA: begin
				evt_n.mapped_buttons = cmd_q.mb;
				evt_n.left_x = axis_out(cmd_q.sx[7], big_x_q, dq_x_q);
				evt_n.left_y = axis_out(cmd_q.ny[7], big_y_q, dq_y_q);
				evt_n.right_x = cmd_q.rx;
				evt_n.right_y = cmd_q.ry;
				evt_n.cleared = 1'b0;
				evt_n.pak_ready = cmd_q.pak;
				evt_n.last = 1'b1;
				if (slot_free) begin
					evt_load = 1'b1;
					state_n = gpn_pkg::B_IDLE;
				end
			end
			default: begin
				state_n = gpn_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpn_pkg::B_IDLE;
			cnt_q <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q <= (state_q == gpn_pkg::B_DIV) ? !cnt_q : 1'b0;
			if (evt_load) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == gpn_pkg::B_PREP) begin
			// quotient fits eight bits unless the product reaches fs * 256
			big_x_q <= n_x >= lim;
			big_y_q <= n_y >= lim;
			rem_x_q <= {1'b0, n_x[14:8]};
			rem_y_q <= {1'b0, n_y[14:8]};
			dq_x_q <= n_x[7:0];
			dq_y_q <= n_y[7:0];
		end else if (state_q == gpn_pkg::B_DIV) begin
			rem_x_q <= st_x[15:8];
			dq_x_q <= st_x[7:0];
			rem_y_q <= st_y[15:8];
			dq_y_q <= st_y[7:0];
		end
		if (evt_load) begin
			evt_q <= evt_n;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt = evt_q;

endmodule

// File: rtl/core/gamepad_poll_normalizer_top.sv
// ----------------------------------------------------------------------------
// gamepad_poll_normalizer_top
// Per-port controller poll tracking, remapping and change-only event output.
// ----------------------------------------------------------------------------
// Usage:
//   poll channel: one beat per controller poll (port, link, report, pak flags),
//     accepted when poll_valid is high and poll_stall is low.
//   evt channel: zero, one or two event beats per poll, in poll order; the
//     final beat of a poll carries last. A disconnect beat (cleared) comes
//     before the report beat of the same poll.
//   cfg port: cfg_we writes cfg_wdata into register cfg_index
//     (0 disconnect_limit, 1 pak_init_poll, 2 stick_full_scale); write only
//     while no poll is in flight.
// Flow: the front takes a poll every cycle while the two-entry work queue
//   has room. The back works on one queued command at a time: pop, multiply
//   by 127, divide in a radix-16 divider, then load each emitted beat into
//   the output register once it is free; it takes no new command until the
//   last beat is loaded. Polls that cause no event are not queued.
// Reset: all ports clear their counters and are forced to emit their first
//   valid report; registers return to 30, 10 and 84.
// Stall: a stalled event beat holds in the output register; the back waits,
//   the queue fills and then poll_stall rises.
// ----------------------------------------------------------------------------
module gamepad_poll_normalizer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              poll_valid,
	output logic              poll_stall,
	input  gpn_pkg::gpn_in_t  poll,
	output logic              evt_valid,
	input  logic              evt_stall,
	output gpn_pkg::gpn_out_t evt,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_wdata
);

	gpn_pkg::gpn_cfg_t cfg_q;
	gpn_pkg::gpn_cmd_t push_cmd, head_cmd;
	logic              q_full, q_push, q_pop, q_valid;

	// Hold configuration; ignore indexes past the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disconnect_limit <= gpn_pkg::GPN_RST_DISCONNECT_LIMIT;
			cfg_q.pak_init_poll <= gpn_pkg::GPN_RST_PAK_INIT_POLL;
			cfg_q.stick_full_scale <= gpn_pkg::GPN_RST_STICK_FULL_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				gpn_pkg::GPN_REG_DISCONNECT_LIMIT: cfg_q.disconnect_limit <= cfg_wdata;
				gpn_pkg::GPN_REG_PAK_INIT_POLL:    cfg_q.pak_init_poll <= cfg_wdata;
				gpn_pkg::GPN_REG_STICK_FULL_SCALE: cfg_q.stick_full_scale <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// Front: classify each poll and update port state.
	gpn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll_valid),
		.poll_stall (poll_stall),
		.poll       (poll),
		.cfg        (cfg_q),
		.cmd_full   (q_full),
		.cmd_push   (q_push),
		.cmd        (push_cmd)
	);

	// Queue: decouple the front from the back, which works on one command at a time.
	gpn_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (head_cmd)
	);

	// Back: scale sticks and drive the event register.
	gpn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.full_scale (cfg_q.stick_full_scale),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt)
	);

endmodule

// File: rtl/core/gpn_checker.sv
// ----------------------------------------------------------------------------
// gpn_checker
// Port-level checks on the event channel of the poll normalizer.
// ----------------------------------------------------------------------------
module gpn_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              evt_valid,
	input logic              evt_stall,
	input gpn_pkg::gpn_out_t evt
);

	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid && $stable(evt))
		else $error("event beat changed under stall");

	// disconnect beat carries neutral values
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.cleared |-> evt.mapped_buttons == 14'd0
			&& evt.left_x == 8'd128 && evt.left_y == 8'd128
			&& evt.right_x == 8'd128 && evt.right_y == 8'd128 && !evt.pak_ready)
		else $error("disconnect beat not neutral");

	// right stick X follows the C-right and C-left bits of the mapped buttons
	a_rx: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt.cleared |-> evt.right_x ==
			(evt.mapped_buttons[9] ? 8'd255 : (evt.mapped_buttons[3] ? 8'd0 : 8'd128)))
		else $error("right stick X disagrees with C buttons");

	// a disconnect beat that is not last is followed at once by its report
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall && evt.cleared && !evt.last |=>
			evt_valid && !evt.cleared && evt.out_port == $past(evt.out_port))
		else $error("report beat missing after disconnect beat");

endmodule

bind gamepad_poll_normalizer_top gpn_checker u_gpn_checker (.*);
